// File: hdl/ftr_pkg.sv
// Shared types and constants for the filled triangle rasterizer.
package ftr_pkg;

  localparam int SCREEN_WIDTH  = 320;
  localparam int SCREEN_HEIGHT = 240;
  localparam int ROW_STRIDE    = 512;
  localparam int COORD_BITS    = 11;
  localparam int COLOR_BITS    = 16;
  localparam int ADDR_BITS     = 17;

  localparam int IN_DATA_BITS  = 88;
  localparam int OUT_DATA_BITS = 56;

  localparam int QUEUE_DEPTH   = 4;
  localparam int PTR_BITS      = $clog2(QUEUE_DEPTH);

  typedef logic signed [COORD_BITS-1:0]   coord_t;
  typedef logic signed [COORD_BITS:0]     delta_t;
  typedef logic signed [2*COORD_BITS+1:0] prod_t;
  typedef logic signed [2*COORD_BITS+2:0] edge_t;
  typedef logic [COLOR_BITS-1:0]          color_t;
  typedef logic [ADDR_BITS-1:0]           addr_t;

  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } op_t;

  // One classified command as it travels from the front end to the back end.
  typedef struct packed {
    op_t              op;
    coord_t [2:0]     vx;
    coord_t [2:0]     vy;
    delta_t [2:0]     ex;
    delta_t [2:0]     ey;
    color_t           color;
    coord_t           min_x;
    coord_t           max_x;
    coord_t           min_y;
    coord_t           max_y;
  } cmd_t;

endpackage

// File: hdl/ftr_front.sv
// Front end: unpacks an input transfer, classifies it and prepares the triangle setup.
module ftr_front (
  input  logic                                 op_bit,
  input  logic [ftr_pkg::IN_DATA_BITS-1:0]     data,
  output ftr_pkg::cmd_t                        cmd
);

  ftr_pkg::coord_t vx [3];
  ftr_pkg::coord_t vy [3];

  function automatic ftr_pkg::coord_t min3(ftr_pkg::coord_t a, ftr_pkg::coord_t b,
                                           ftr_pkg::coord_t c);
    ftr_pkg::coord_t m;
    m = a;
    if ($signed(b) < $signed(m)) m = b;
    if ($signed(c) < $signed(m)) m = c;
    return m;
  endfunction

  function automatic ftr_pkg::coord_t max3(ftr_pkg::coord_t a, ftr_pkg::coord_t b,
                                           ftr_pkg::coord_t c);
    ftr_pkg::coord_t m;
    m = a;
    if ($signed(b) > $signed(m)) m = b;
    if ($signed(c) > $signed(m)) m = c;
    return m;
  endfunction

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vx[i] = data[2*i*ftr_pkg::COORD_BITS +: ftr_pkg::COORD_BITS];
      vy[i] = data[(2*i+1)*ftr_pkg::COORD_BITS +: ftr_pkg::COORD_BITS];
    end
  end

  always_comb begin
    cmd.op    = op_bit ? ftr_pkg::OP_STEP : ftr_pkg::OP_START;
    cmd.color = data[6*ftr_pkg::COORD_BITS +: ftr_pkg::COLOR_BITS];
    for (int i = 0; i < 3; i++) begin
      cmd.vx[i] = vx[i];
      cmd.vy[i] = vy[i];
      // Edge i runs from vertex i to vertex i+1, wrapping from C back to A.
      cmd.ex[i] = ftr_pkg::delta_t'($signed(vx[(i+1)%3])) - ftr_pkg::delta_t'($signed(vx[i]));
      cmd.ey[i] = ftr_pkg::delta_t'($signed(vy[(i+1)%3])) - ftr_pkg::delta_t'($signed(vy[i]));
    end
    cmd.min_x = min3(vx[0], vx[1], vx[2]);
    cmd.max_x = max3(vx[0], vx[1], vx[2]);
    cmd.min_y = min3(vy[0], vy[1], vy[2]);
    cmd.max_y = max3(vy[0], vy[1], vy[2]);
  end

endmodule

// File: hdl/ftr_queue.sv
// Small command queue between the front end and the back end.
module ftr_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  ftr_pkg::cmd_t push_cmd,
  output logic          ready,
  input  logic          pop,
  output logic          head_valid,
  output ftr_pkg::cmd_t head
);

  ftr_pkg::cmd_t                   entries [ftr_pkg::QUEUE_DEPTH];
  logic [ftr_pkg::PTR_BITS-1:0]    wr_ptr;
  logic [ftr_pkg::PTR_BITS-1:0]    rd_ptr;
  logic [ftr_pkg::PTR_BITS:0]      count;
  logic                            do_push;
  logic                            do_pop;

  assign ready      = count != (ftr_pkg::PTR_BITS+1)'(ftr_pkg::QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head       = entries[rd_ptr];
  assign do_push    = push && ready;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_cmd;
  end

endmodule

// File: hdl/ftr_back.sv
// Back end: bounding box scan and pipelined edge function test.
module ftr_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_valid,
  input  ftr_pkg::cmd_t         cmd,
  output logic                  cmd_pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_we,
  output ftr_pkg::addr_t        out_addr,
  output ftr_pkg::coord_t       out_x,
  output ftr_pkg::coord_t       out_y,
  output ftr_pkg::color_t       out_color,
  output logic                  out_last
);

  // Triangle state.
  logic            active;
  ftr_pkg::coord_t tri_vx [3];
  ftr_pkg::coord_t tri_vy [3];
  ftr_pkg::delta_t tri_ex [3];
  ftr_pkg::delta_t tri_ey [3];
  ftr_pkg::color_t tri_color;
  ftr_pkg::coord_t min_x;
  ftr_pkg::coord_t max_x;
  ftr_pkg::coord_t max_y;
  ftr_pkg::coord_t scan_x;
  ftr_pkg::coord_t scan_y;

  // Stage 1: visited point.
  logic            p1_valid;
  ftr_pkg::coord_t p1_x, p1_y;
  ftr_pkg::coord_t p1_vx [3];
  ftr_pkg::coord_t p1_vy [3];
  ftr_pkg::delta_t p1_ex [3];
  ftr_pkg::delta_t p1_ey [3];
  ftr_pkg::color_t p1_color;
  logic            p1_last;

  // Stage 2: offsets from each edge origin.
  logic            p2_valid;
  ftr_pkg::coord_t p2_x, p2_y;
  ftr_pkg::delta_t p2_dx [3];
  ftr_pkg::delta_t p2_dy [3];
  ftr_pkg::delta_t p2_ex [3];
  ftr_pkg::delta_t p2_ey [3];
  ftr_pkg::color_t p2_color;
  logic            p2_last;

  // Stage 3: products.
  logic            p3_valid;
  ftr_pkg::coord_t p3_x, p3_y;
  ftr_pkg::prod_t  p3_pa [3];
  ftr_pkg::prod_t  p3_pb [3];
  ftr_pkg::color_t p3_color;
  logic            p3_last;

  logic            adv;
  logic            issue_start;
  logic            issue_step;
  logic            at_row_end;
  logic            at_last;
  ftr_pkg::edge_t  edge_val [3];
  logic            all_nonneg;
  logic            all_nonpos;
  logic            on_screen;
  logic            in_tri;
  ftr_pkg::addr_t  addr_calc;

  assign adv         = !out_valid || out_ready;
  assign cmd_pop     = cmd_valid && adv;
  assign issue_start = cmd_pop && (cmd.op == ftr_pkg::OP_START);
  assign issue_step  = cmd_pop && (cmd.op == ftr_pkg::OP_STEP) && active;
  assign at_row_end  = scan_x == max_x;
  assign at_last     = at_row_end && (scan_y == max_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      p1_valid  <= 1'b0;
      p2_valid  <= 1'b0;
      p3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      p1_valid  <= issue_step;
      p2_valid  <= p1_valid;
      p3_valid  <= p2_valid;
      out_valid <= p3_valid;
      if (issue_start) active <= 1'b1;
      else if (issue_step && at_last) active <= 1'b0;
    end
  end

  // Setup and scan position.
  always_ff @(posedge clk) begin
    if (issue_start) begin
      for (int i = 0; i < 3; i++) begin
        tri_vx[i] <= cmd.vx[i];
        tri_vy[i] <= cmd.vy[i];
        tri_ex[i] <= cmd.ex[i];
        tri_ey[i] <= cmd.ey[i];
      end
      tri_color <= cmd.color;
      min_x     <= cmd.min_x;
      max_x     <= cmd.max_x;
      max_y     <= cmd.max_y;
      scan_x    <= cmd.min_x;
      scan_y    <= cmd.min_y;
    end else if (issue_step && !at_last) begin
      if (at_row_end) begin
        scan_x <= min_x;
        scan_y <= scan_y + 1'b1;
      end else begin
        scan_x <= scan_x + 1'b1;
      end
    end
  end

  // Datapath stages, all held while the output register is stalled.
  always_ff @(posedge clk) begin
    if (adv) begin
      p1_x     <= scan_x;
      p1_y     <= scan_y;
      p1_color <= tri_color;
      p1_last  <= at_last;
      for (int i = 0; i < 3; i++) begin
        p1_vx[i] <= tri_vx[i];
        p1_vy[i] <= tri_vy[i];
        p1_ex[i] <= tri_ex[i];
        p1_ey[i] <= tri_ey[i];
      end

      p2_x     <= p1_x;
      p2_y     <= p1_y;
      p2_color <= p1_color;
      p2_last  <= p1_last;
      for (int i = 0; i < 3; i++) begin
        p2_dx[i] <= ftr_pkg::delta_t'($signed(p1_x)) - ftr_pkg::delta_t'($signed(p1_vx[i]));
        p2_dy[i] <= ftr_pkg::delta_t'($signed(p1_y)) - ftr_pkg::delta_t'($signed(p1_vy[i]));
        p2_ex[i] <= p1_ex[i];
        p2_ey[i] <= p1_ey[i];
      end

      p3_x     <= p2_x;
      p3_y     <= p2_y;
      p3_color <= p2_color;
      p3_last  <= p2_last;
      for (int i = 0; i < 3; i++) begin
        p3_pa[i] <= $signed(p2_ex[i]) * $signed(p2_dy[i]);
        p3_pb[i] <= $signed(p2_dx[i]) * $signed(p2_ey[i]);
      end

      out_we    <= in_tri && on_screen;
      out_addr  <= (in_tri && on_screen) ? addr_calc : '0;
      out_x     <= p3_x;
      out_y     <= p3_y;
      out_color <= p3_color;
      out_last  <= p3_last;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      edge_val[i] = ftr_pkg::edge_t'($signed(p3_pa[i])) - ftr_pkg::edge_t'($signed(p3_pb[i]));
    end
    all_nonneg = !edge_val[0][$bits(ftr_pkg::edge_t)-1] && !edge_val[1][$bits(ftr_pkg::edge_t)-1]
              && !edge_val[2][$bits(ftr_pkg::edge_t)-1];
    all_nonpos = (edge_val[0][$bits(ftr_pkg::edge_t)-1] || edge_val[0] == '0)
              && (edge_val[1][$bits(ftr_pkg::edge_t)-1] || edge_val[1] == '0)
              && (edge_val[2][$bits(ftr_pkg::edge_t)-1] || edge_val[2] == '0);
    in_tri     = all_nonneg || all_nonpos;
    // Both coordinates must be non-negative before the unsigned bound compare.
    on_screen  = !p3_x[ftr_pkg::COORD_BITS-1] && !p3_y[ftr_pkg::COORD_BITS-1]
              && ({1'b0, p3_x} < (ftr_pkg::COORD_BITS+1)'(ftr_pkg::SCREEN_WIDTH))
              && ({1'b0, p3_y} < (ftr_pkg::COORD_BITS+1)'(ftr_pkg::SCREEN_HEIGHT));
    addr_calc  = ftr_pkg::ADDR_BITS'(ftr_pkg::ADDR_BITS'(unsigned'(p3_y))
               * ftr_pkg::ADDR_BITS'(ftr_pkg::ROW_STRIDE))
               + ftr_pkg::ADDR_BITS'(unsigned'(p3_x));
  end

endmodule

// File: hdl/filled_triangle_rasterizer.sv
// Top level of the filled triangle rasterizer.
//
// Input stream (s_axis): tuser carries the operation, 0 starts a triangle and
// 1 steps one point; tdata carries the three vertices and the fill color.
// A start transfer latches the triangle and its bounding box and gives no
// output; it aborts any triangle still being scanned. Each step transfer
// visits the next point of the box in row-major order and gives one output
// transfer, or none when no triangle is active.
// Output stream (m_axis): tuser is the write flag, tdata holds the framebuffer
// address (y*512+x), the point and the color, tlast marks the final point.
// Throughput is one point per clock while the output is not stalled. A step is
// registered in the command queue, then passes the scan, offset, multiply and
// edge test stages to the output register.
// A four-entry command queue lets the input keep accepting while the output
// stalls; when the receiver holds tready low the whole back-end pipeline
// holds and the queue fills, after which s_axis_tready falls.
// Reset (rst, synchronous) empties the queue and pipeline and leaves no
// triangle active.
module filled_triangle_rasterizer (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [10:0] vertex_a_x, [21:11] vertex_a_y, [32:22] vertex_b_x, [43:33] vertex_b_y,
  // [54:44] vertex_c_x, [65:55] vertex_c_y, [81:66] fill_color, [87:82] zero
  input  logic [ftr_pkg::IN_DATA_BITS-1:0]    s_axis_tdata,
  // [0] operation
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [16:0] write_address, [27:17] point_x, [38:28] point_y, [54:39] pixel_color,
  // [55] zero
  output logic [ftr_pkg::OUT_DATA_BITS-1:0]   m_axis_tdata,
  // [0] write_enable
  output logic                                m_axis_tuser,
  output logic                                m_axis_tlast
);

  ftr_pkg::cmd_t   in_cmd;
  ftr_pkg::cmd_t   head_cmd;
  logic            head_valid;
  logic            head_pop;
  logic            out_we;
  ftr_pkg::addr_t  out_addr;
  ftr_pkg::coord_t out_x;
  ftr_pkg::coord_t out_y;
  ftr_pkg::color_t out_color;
  logic            out_last;

  ftr_front u_front (
    .op_bit (s_axis_tuser),
    .data   (s_axis_tdata),
    .cmd    (in_cmd)
  );

  ftr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (s_axis_tvalid),
    .push_cmd   (in_cmd),
    .ready      (s_axis_tready),
    .pop        (head_pop),
    .head_valid (head_valid),
    .head       (head_cmd)
  );

  ftr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (head_valid),
    .cmd       (head_cmd),
    .cmd_pop   (head_pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_we    (out_we),
    .out_addr  (out_addr),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_color (out_color),
    .out_last  (out_last)
  );

  assign m_axis_tdata = {1'b0, out_color, out_y, out_x, out_addr};
  assign m_axis_tuser = out_we;
  assign m_axis_tlast = out_last;

endmodule

// File: test/filled_triangle_rasterizer_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the filled triangle rasterizer: directed and random triangles.
module filled_triangle_rasterizer_tb;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 16;

  typedef struct {
    logic            write_en;
    ftr_pkg::addr_t  addr;
    ftr_pkg::coord_t x;
    ftr_pkg::coord_t y;
    ftr_pkg::color_t color;
    logic            last;
  } pixel_t;

  logic                              clk = 1'b0;
  logic                              rst;
  logic                              s_axis_tvalid;
  logic                              s_axis_tready;
  logic [ftr_pkg::IN_DATA_BITS-1:0]  s_axis_tdata;
  logic                              s_axis_tuser;
  logic                              m_axis_tvalid;
  logic                              m_axis_tready;
  logic [ftr_pkg::OUT_DATA_BITS-1:0] m_axis_tdata;
  logic                              m_axis_tuser;
  logic                              m_axis_tlast;

  // Scan state of the triangle as the block should see it.
  int              tri_vx[3];
  int              tri_vy[3];
  ftr_pkg::color_t tri_color;
  int              box_x_lo, box_x_hi, box_y_lo, box_y_hi;
  int              scan_x, scan_y;
  logic            scan_active = 1'b0;

  pixel_t      pending_pixels[$];
  int          pixel_errors = 0;
  int          items_sent = 0;
  int unsigned cycle_count = 0;
  logic        tx_gaps = 1'b1;
  logic        rx_gaps = 1'b1;
  logic        hold_request = 1'b0;

  filled_triangle_rasterizer i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d pixels outstanding", $time, pending_pixels.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic int edge_value(int ax, int ay, int bx, int by, int x, int y);
    return (bx - ax) * (y - ay) - (x - ax) * (by - ay);
  endfunction

  // Updates the scan state for one accepted transfer and queues the pixel it produces.
  task automatic next_pixel(input ftr_pkg::op_t op,
                            input logic [ftr_pkg::IN_DATA_BITS-1:0] data);
    int     i;
    int     e0, e1, e2;
    logic   in_tri, on_screen;
    pixel_t px;
    if (op == ftr_pkg::OP_START) begin
      for (i = 0; i < 3; i++) begin
        tri_vx[i] = int'(ftr_pkg::coord_t'(data[22*i +: ftr_pkg::COORD_BITS]));
        tri_vy[i] = int'(ftr_pkg::coord_t'(data[22*i+ftr_pkg::COORD_BITS +: ftr_pkg::COORD_BITS]));
      end
      tri_color = data[66 +: ftr_pkg::COLOR_BITS];
      box_x_lo = tri_vx[0];
      box_x_hi = tri_vx[0];
      box_y_lo = tri_vy[0];
      box_y_hi = tri_vy[0];
      for (i = 1; i < 3; i++) begin
        if (tri_vx[i] < box_x_lo) box_x_lo = tri_vx[i];
        if (tri_vx[i] > box_x_hi) box_x_hi = tri_vx[i];
        if (tri_vy[i] < box_y_lo) box_y_lo = tri_vy[i];
        if (tri_vy[i] > box_y_hi) box_y_hi = tri_vy[i];
      end
      scan_x = box_x_lo;
      scan_y = box_y_lo;
      scan_active = 1'b1;
    end else if (scan_active) begin
      e0 = edge_value(tri_vx[0], tri_vy[0], tri_vx[1], tri_vy[1], scan_x, scan_y);
      e1 = edge_value(tri_vx[1], tri_vy[1], tri_vx[2], tri_vy[2], scan_x, scan_y);
      e2 = edge_value(tri_vx[2], tri_vy[2], tri_vx[0], tri_vy[0], scan_x, scan_y);
      in_tri = (e0 >= 0 && e1 >= 0 && e2 >= 0) || (e0 <= 0 && e1 <= 0 && e2 <= 0);
      on_screen = scan_x >= 0 && scan_x < ftr_pkg::SCREEN_WIDTH
               && scan_y >= 0 && scan_y < ftr_pkg::SCREEN_HEIGHT;
      px.write_en = in_tri && on_screen;
      px.addr     = px.write_en ? ftr_pkg::addr_t'(scan_y * ftr_pkg::ROW_STRIDE + scan_x) : '0;
      px.x        = ftr_pkg::coord_t'(scan_x);
      px.y        = ftr_pkg::coord_t'(scan_y);
      px.color    = tri_color;
      px.last     = scan_x == box_x_hi && scan_y == box_y_hi;
      pending_pixels.push_back(px);
      if (px.last) begin
        scan_active = 1'b0;
      end else if (scan_x == box_x_hi) begin
        scan_x = box_x_lo;
        scan_y++;
      end else begin
        scan_x++;
      end
    end
  endtask

  // Valid is only lowered for a gap, so back-to-back transfers keep it high.
  task automatic send_item(input ftr_pkg::op_t op,
                           input logic [ftr_pkg::IN_DATA_BITS-1:0] data);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= data;
    do @(posedge clk); while (!s_axis_tready);
    next_pixel(op, data);
    items_sent++;
    if (tx_gaps && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  task automatic start_triangle(input int ax, input int ay, input int bx, input int by,
                                input int cx, input int cy, input int color);
    send_item(ftr_pkg::OP_START,
              {6'b0, ftr_pkg::color_t'(color), ftr_pkg::coord_t'(cy), ftr_pkg::coord_t'(cx),
               ftr_pkg::coord_t'(by), ftr_pkg::coord_t'(bx), ftr_pkg::coord_t'(ay),
               ftr_pkg::coord_t'(ax)});
  endtask

  // Step payload bits are ignored by the block, so they carry noise.
  task automatic step_point();
    logic [95:0] noise;
    noise = {$urandom, $urandom, $urandom};
    noise[95:82] = '0;
    send_item(ftr_pkg::OP_STEP, noise[ftr_pkg::IN_DATA_BITS-1:0]);
  endtask

  task automatic finish_triangle();
    while (scan_active) step_point();
  endtask

  task automatic test_idle_steps();
    step_point();
  endtask

  task automatic test_coordinate_extremes();
    // Huge box, abandoned after two points by the next start.
    start_triangle(-1024, -1024, 1023, -1024, -1024, 1023, 16'hFFFF);
    repeat (2) step_point();
    start_triangle(1022, 1022, 1023, 1023, 1023, 1022, 16'h0000);
    finish_triangle();
    step_point();
    start_triangle(-1024, -1024, -1023, -1024, -1024, -1023, 16'hA5A5);
    finish_triangle();
  endtask

  task automatic test_degenerate_triangles();
    start_triangle(5, 5, 5, 5, 5, 5, 16'h1234);
    finish_triangle();
    start_triangle(10, 10, 11, 11, 10, 10, 16'h5A5A);
    finish_triangle();
  endtask

  task automatic test_screen_clipping();
    start_triangle(319, 239, 320, 240, 320, 239, 16'h8001);
    finish_triangle();
    start_triangle(-1, -1, 0, 0, 0, -1, 16'h7FFE);
    finish_triangle();
  endtask

  // Mostly complete scans of small triangles, with aborts, wild vertices and stray steps.
  task automatic test_random_triangles(input int target);
    int kind, ox, oy, spread, stop_at, placed;
    while (items_sent < target) begin
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
        repeat ($urandom_range(1, 3)) step_point();
      end else if (kind < 16) begin
        start_triangle(int'($urandom_range(0, 2047)) - 1024, int'($urandom_range(0, 2047)) - 1024,
                       int'($urandom_range(0, 2047)) - 1024, int'($urandom_range(0, 2047)) - 1024,
                       int'($urandom_range(0, 2047)) - 1024, int'($urandom_range(0, 2047)) - 1024,
                       $urandom_range(0, 65535));
        repeat ($urandom_range(0, 12)) step_point();
      end else begin
        case ($urandom_range(0, 9))
          0: begin
            ox = -1024;
            oy = 1016;
          end
          1: begin
            ox = 1016;
            oy = -1024;
          end
          default: begin
            ox = int'($urandom_range(0, 335)) - 8;
            oy = int'($urandom_range(0, 255)) - 8;
          end
        endcase
        spread = $urandom_range(0, 7);
        start_triangle(ox + int'($urandom_range(0, spread)), oy + int'($urandom_range(0, spread)),
                       ox + int'($urandom_range(0, spread)), oy + int'($urandom_range(0, spread)),
                       ox + int'($urandom_range(0, spread)), oy + int'($urandom_range(0, spread)),
                       $urandom_range(0, 65535));
        stop_at = (kind < 35) ? int'($urandom_range(0, 20)) : -1;
        placed = 0;
        while (scan_active && placed != stop_at) begin
          step_point();
          placed++;
        end
      end
    end
  endtask

  // The receiver stalls long enough for the command queue to fill and the input to stall.
  task automatic test_output_backpressure();
    tx_gaps = 1'b0;
    hold_request = 1'b1;
    start_triangle(100, 100, 107, 100, 100, 107, $urandom_range(0, 65535));
    finish_triangle();
    tx_gaps = 1'b1;
  endtask

  task automatic test_streaming_tail(input int target);
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    test_random_triangles(target);
  endtask

  initial begin
    m_axis_tready = 1'b1;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else if (rx_gaps && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 19) - 1) @(posedge clk);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic check_field(input string name, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      pixel_errors++;
    end
  endtask

  always @(posedge clk) begin : check_output
    pixel_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected output transfer, tdata %h tuser %b tlast %b",
                 $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
        pixel_errors++;
      end else begin
        want = pending_pixels.pop_front();
        check_field("write_enable", want.write_en, m_axis_tuser);
        check_field("write_address", want.addr, m_axis_tdata[16:0]);
        check_field("point_x", want.x, ftr_pkg::coord_t'(m_axis_tdata[27:17]));
        check_field("point_y", want.y, ftr_pkg::coord_t'(m_axis_tdata[38:28]));
        check_field("pixel_color", want.color, m_axis_tdata[54:39]);
        check_field("last_point", want.last, m_axis_tlast);
      end
    end
  end

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_idle_steps();
    test_coordinate_extremes();
    test_degenerate_triangles();
    test_screen_clipping();
    test_random_triangles(700);
    test_output_backpressure();
    test_random_triangles(1350);
    test_streaming_tail(1550);
    s_axis_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pixel_errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/ftr_pkg.sv
hdl/ftr_front.sv
hdl/ftr_queue.sv
hdl/ftr_back.sv
hdl/filled_triangle_rasterizer.sv
test/filled_triangle_rasterizer_tb.sv
